// ----- hdl/mlru_pkg.sv -----
// Shared constants and controller/datapath interface types for the matrix LRU
// page replacement core. Used by mlru_ctrl, mlru_datapath and the top level.
// No dependencies.
package mlru_pkg;

  localparam int DEF_MAX_FRAMES = 8;
  localparam int DEF_PAGE_BITS  = 16;
  localparam int CFG_W          = 4;
  localparam int COUNT_W        = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(8);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the page of an accepted beat
    logic lookup;     // resolve hit or empty frame, prime the victim scan
    logic scan_step;  // compare one more matrix row against the best so far
    logic commit;     // update frames, matrix and counter, emit the result
  } mlru_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic found;      // hit or empty frame available, no victim needed
    logic single;     // only one frame active, victim is frame zero
    logic scan_last;  // the current scan step covers the last active row
  } mlru_sts_t;

endpackage

// ----- hdl/mlru_ctrl.sv -----
// Sequencing state machine of the matrix LRU page replacement core.
// Depends on mlru_pkg for the command and status structs.
module mlru_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mlru_pkg::mlru_sts_t sts,
  output mlru_pkg::mlru_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        if (sts.found || sts.single) begin
          state_nxt = ST_UPDATE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- hdl/mlru_datapath.sv -----
// Frame table, LRU bit matrix, victim scan and fault counter of the matrix LRU
// page replacement core. Depends on mlru_pkg; driven by mlru_ctrl.
module mlru_datapath #(
  parameter int MAX_FRAMES = mlru_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = mlru_pkg::DEF_PAGE_BITS,
  parameter int FRAME_W    = $clog2(MAX_FRAMES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mlru_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic [PAGE_BITS-1:0]         in_page_number,
  input  mlru_pkg::mlru_cmd_t          cmd,
  output mlru_pkg::mlru_sts_t          sts,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [FRAME_W-1:0]           out_frame_index,
  output logic                         out_evicted_valid,
  output logic [PAGE_BITS-1:0]         out_evicted_page,
  output logic [mlru_pkg::COUNT_W-1:0] out_fault_total
);

  localparam int NW = $clog2(MAX_FRAMES + 1);

  logic [mlru_pkg::CFG_W-1:0]   frames_r;
  logic [PAGE_BITS-1:0]         page_r;
  logic [PAGE_BITS-1:0]         resident_r [MAX_FRAMES];
  logic [MAX_FRAMES-1:0]        valid_r;
  logic [MAX_FRAMES-1:0]        age_r [MAX_FRAMES];
  logic [mlru_pkg::COUNT_W-1:0] fault_cnt_r;
  logic                         hit_r;
  logic                         empty_r;
  logic [FRAME_W-1:0]           frame_r;
  logic [FRAME_W-1:0]           best_idx_r;
  logic [MAX_FRAMES-1:0]        best_row_r;
  logic [FRAME_W-1:0]           scan_idx_r;

  logic                         out_valid_r;
  logic                         out_hit_r;
  logic [FRAME_W-1:0]           out_frame_r;
  logic                         out_evicted_r;
  logic [PAGE_BITS-1:0]         out_evicted_page_r;

  logic [NW-1:0]                n_active;
  logic [MAX_FRAMES-1:0]        active;
  logic [MAX_FRAMES-1:0]        match;
  logic [MAX_FRAMES-1:0]        empty;
  logic [FRAME_W-1:0]           match_idx;
  logic [FRAME_W-1:0]           empty_idx;
  logic [MAX_FRAMES-1:0]        ones_mask;
  logic [MAX_FRAMES-1:0]        scan_row;
  logic                         evict;
  logic [FRAME_W-1:0]           tgt_idx;
  logic [MAX_FRAMES-1:0]        tgt_col;
  logic [mlru_pkg::COUNT_W-1:0] fault_cnt_nxt;

  // Out-of-range frame counts are clamped into 1..MAX_FRAMES.
  always_comb begin
    if (frames_r == '0) begin
      n_active = NW'(1);
    end else if (32'(frames_r) > 32'(MAX_FRAMES)) begin
      n_active = NW'(MAX_FRAMES);
    end else begin
      n_active = NW'(frames_r);
    end
  end

  // Parallel compare against every frame; the lowest matching frame wins.
  always_comb begin
    match_idx = '0;
    empty_idx = '0;
    ones_mask = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      active[i] = (32'(i) < 32'(n_active));
      match[i]  = active[i] && valid_r[i] && (resident_r[i] == page_r);
      empty[i]  = active[i] && !valid_r[i];
      // Column j lives at bit MAX_FRAMES-1-j so rows rank as plain numbers.
      ones_mask[MAX_FRAMES-1-i] = active[i];
    end
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = FRAME_W'(i);
      end
      if (empty[i]) begin
        empty_idx = FRAME_W'(i);
      end
    end
  end

  assign scan_row = age_r[scan_idx_r];

  assign sts.found     = (|match) || (|empty);
  assign sts.single    = (n_active == NW'(1));
  assign sts.scan_last = ((NW'(scan_idx_r) + NW'(1)) == n_active);

  assign evict   = !hit_r && !empty_r;
  assign tgt_idx = evict ? best_idx_r : frame_r;

  always_comb begin
    tgt_col = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (FRAME_W'(i) == tgt_idx) begin
        tgt_col[MAX_FRAMES-1-i] = 1'b1;
      end
    end
  end

  always_comb begin
    fault_cnt_nxt = fault_cnt_r;
    if (!hit_r && (fault_cnt_r != '1)) begin
      fault_cnt_nxt = fault_cnt_r + mlru_pkg::COUNT_W'(1);
    end
  end

  // Control state: configuration, valid bits, matrix, counter, strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r    <= mlru_pkg::FRAMES_RESET;
      valid_r     <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < MAX_FRAMES; r++) begin
        age_r[r] <= '0;
      end
    end else begin
      out_valid_r <= cmd.commit;
      if (cfg_wr_en) begin
        frames_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        valid_r[tgt_idx] <= 1'b1;
        fault_cnt_r      <= fault_cnt_nxt;
        for (int r = 0; r < MAX_FRAMES; r++) begin
          if (FRAME_W'(r) == tgt_idx) begin
            age_r[r] <= ones_mask & ~tgt_col;
          end else if (active[r]) begin
            age_r[r] <= age_r[r] & ~tgt_col;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r <= in_page_number;
    end
    if (cmd.lookup) begin
      hit_r      <= |match;
      empty_r    <= !(|match) && (|empty);
      frame_r    <= (|match) ? match_idx : empty_idx;
      best_idx_r <= '0;
      best_row_r <= age_r[0];
      scan_idx_r <= FRAME_W'(1);
    end
    if (cmd.scan_step) begin
      // Strictly smaller only, so the lowest row keeps a tie.
      if (scan_row < best_row_r) begin
        best_idx_r <= scan_idx_r;
        best_row_r <= scan_row;
      end
      scan_idx_r <= scan_idx_r + FRAME_W'(1);
    end
    if (cmd.commit) begin
      if (!hit_r) begin
        resident_r[tgt_idx] <= page_r;
      end
      out_hit_r          <= hit_r;
      out_frame_r        <= tgt_idx;
      out_evicted_r      <= evict;
      out_evicted_page_r <= evict ? resident_r[tgt_idx] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = out_frame_r;
  assign out_evicted_valid = out_evicted_r;
  assign out_evicted_page  = out_evicted_page_r;
  assign out_fault_total   = fault_cnt_r;

endmodule

// ----- hdl/matrix_lru_page_replacement_core.sv -----
// Top level of the matrix LRU page replacement core.
// Depends on mlru_pkg, mlru_ctrl and mlru_datapath.
//
// Usage:
//   Each input beat carries one page reference on in_page_number. A beat is
//   taken at a rising edge where start is high and busy is low. The core then
//   looks the page up among the active frames, picks an empty frame or an LRU
//   victim on a miss, and updates its bit matrix.
//   Exactly one result beat follows each input beat. It is presented for a
//   single cycle with out_valid high; the receiver cannot stall it, so it
//   must take the beat in that cycle. out_fault_total holds the fault count
//   including the reported reference.
//   After the accepting edge the page is registered, the lookup state resolves
//   a hit or an empty frame, and the update state commits and registers the
//   result; when a victim must be found, a scan state lies between lookup and
//   update. The victim search walks the matrix rows one per cycle through a
//   single comparator. The core takes no new beat before the last result is
//   out: busy is low again in the cycle in which out_valid is high, so the
//   next beat can be taken on the edge that ends it.
//   The frame count register is written through cfg_wr_en and cfg_wr_data;
//   the user must write it only while the core is idle, as the core itself
//   does not enforce this. Reset (rst_n low, synchronous) empties all frames,
//   clears the matrix and fault count, and sets eight frames.
module matrix_lru_page_replacement_core #(
  parameter int MAX_FRAMES = mlru_pkg::DEF_MAX_FRAMES,
  parameter int PAGE_BITS  = mlru_pkg::DEF_PAGE_BITS,
  parameter int FRAME_W    = $clog2(MAX_FRAMES)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration write port for the frame count.
  input  logic                         cfg_wr_en,
  input  logic [mlru_pkg::CFG_W-1:0]   cfg_wr_data,
  // Input channel.
  input  logic                         start,
  output logic                         busy,
  input  logic [PAGE_BITS-1:0]         in_page_number,
  // Result channel.
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [FRAME_W-1:0]           out_frame_index,
  output logic                         out_evicted_valid,
  output logic [PAGE_BITS-1:0]         out_evicted_page,
  output logic [mlru_pkg::COUNT_W-1:0] out_fault_total
);

  mlru_pkg::mlru_cmd_t cmd;
  mlru_pkg::mlru_sts_t sts;

  // The controller steps through lookup, victim scan and update; it only
  // sees the datapath through the command and status structs.
  mlru_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath holds the frame table, valid bits, LRU matrix, the
  // running fault count and the registered result beat.
  mlru_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_W    (FRAME_W)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_page_number    (in_page_number),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

endmodule

// ----- dv/mlru_replacement_checker.sv -----
// Checker for the matrix LRU page replacement core: watches the configuration,
// reference and result channels, predicts each result and compares it.
// Depends on mlru_pkg for port widths and the reset frame count.
module mlru_replacement_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [mlru_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                         start,
  input  logic                         busy,
  input  logic [15:0]                  in_page_number,
  input  logic                         out_valid,
  input  logic                         out_hit,
  input  logic [2:0]                   out_frame_index,
  input  logic                         out_evicted_valid,
  input  logic [15:0]                  out_evicted_page,
  input  logic [mlru_pkg::COUNT_W-1:0] out_fault_total,
  output int                           mismatch_count,
  output int                           pending_count,
  output int                           hits_seen,
  output int                           evictions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = mlru_pkg::DEF_MAX_FRAMES;
  localparam int PAGE_W = mlru_pkg::DEF_PAGE_BITS;

  typedef struct packed {
    logic                         hit;
    logic [2:0]                   frame;
    logic                         evicted;
    logic [PAGE_W-1:0]            evicted_page;
    logic [mlru_pkg::COUNT_W-1:0] faults;
  } lru_outcome_t;

  // Shadow copy of the replacement state. Row bit FRAMES-1-j holds column j,
  // so comparing rows as numbers ranks them by age.
  logic [PAGE_W-1:0]            page_tbl [FRAMES];
  logic [FRAMES-1:0]            valid_bits;
  logic [FRAMES-1:0]            age_row [FRAMES];
  logic [mlru_pkg::COUNT_W-1:0] faults;
  logic [mlru_pkg::CFG_W-1:0]   frames_reg;
  lru_outcome_t                 outcome_q [$];

  function automatic lru_outcome_t resolve_reference(input logic [PAGE_W-1:0] pg);
    lru_outcome_t      res;
    int                n;
    int                f;
    bit                done;
    logic [FRAMES-1:0] ones;
    n = (frames_reg == 0) ? 1 : (frames_reg > FRAMES) ? FRAMES : int'(frames_reg);
    res = '0;
    done = 1'b0;
    f = 0;
    for (int i = 0; i < n; i++) begin
      if (!done && valid_bits[i] && page_tbl[i] == pg) begin
        done = 1'b1;
        f = i;
        res.hit = 1'b1;
      end
    end
    if (!res.hit) begin
      for (int i = 0; i < n; i++) begin
        if (!done && !valid_bits[i]) begin
          done = 1'b1;
          f = i;
        end
      end
      if (!done) begin
        // Smallest row is least recently used; the lower row wins a tie.
        for (int i = 1; i < n; i++) begin
          if (age_row[i] < age_row[f]) f = i;
        end
        res.evicted = 1'b1;
        res.evicted_page = page_tbl[f];
      end
      page_tbl[f] = pg;
      valid_bits[f] = 1'b1;
      if (faults != '1) faults = faults + mlru_pkg::COUNT_W'(1);
    end
    ones = '0;
    for (int j = 0; j < n; j++) ones[FRAMES-1-j] = 1'b1;
    age_row[f] = ones;
    for (int j = 0; j < n; j++) age_row[j][FRAMES-1-f] = 1'b0;
    res.frame = 3'(f);
    res.faults = faults;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    lru_outcome_t want;
    if (!rst_n) begin
      valid_bits = '0;
      foreach (age_row[i]) age_row[i] = '0;
      foreach (page_tbl[i]) page_tbl[i] = '0;
      faults = '0;
      frames_reg = mlru_pkg::FRAMES_RESET;
      outcome_q.delete();
    end else begin
      if (out_valid) begin
        if (outcome_q.size() == 0) begin
          $error("result beat arrived with no page reference outstanding");
          mismatch_count++;
        end else begin
          want = outcome_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(out_hit));
          check_field("frame_index", 32'(want.frame), 32'(out_frame_index));
          check_field("evicted_valid", 32'(want.evicted), 32'(out_evicted_valid));
          check_field("evicted_page", 32'(want.evicted_page), 32'(out_evicted_page));
          check_field("fault_total", want.faults, out_fault_total);
          if (want.hit) hits_seen++;
          if (want.evicted) evictions_seen++;
        end
      end
      if (cfg_wr_en) frames_reg = cfg_wr_data;
      if (start && !busy) begin
        outcome_q.insert(outcome_q.size(), resolve_reference(in_page_number));
      end
    end
    pending_count = outcome_q.size();
  end

endmodule

// ----- dv/tb.sv -----
// Top of the testbench for the matrix LRU page replacement core: clock, reset,
// reference stimulus, frame count writes and the final verdict.
// Depends on mlru_pkg, the core and mlru_replacement_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_wr_en;
  logic [mlru_pkg::CFG_W-1:0]   cfg_wr_data;
  logic                         start;
  logic                         busy;
  logic [15:0]                  in_page_number;
  logic                         out_valid;
  logic                         out_hit;
  logic [2:0]                   out_frame_index;
  logic                         out_evicted_valid;
  logic [15:0]                  out_evicted_page;
  logic [mlru_pkg::COUNT_W-1:0] out_fault_total;

  int mismatch_count;
  int pending_count;
  int hits_seen;
  int evictions_seen;
  int cycle_count;
  int refs_sent;
  int settings_used;
  int idle_pct;

  // The opening references run with the eight frames that reset leaves.
  // Both page extremes go in and both come back as hits, the set fills up and
  // the last few references force evictions of the least recently used pages.
  logic [15:0] opening_refs [14] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0004, 16'h0008,
    16'h8000, 16'h7FFF, 16'hFFFF, 16'h1234, 16'h0001, 16'h5555, 16'hAAAA
  };

  // Frame counts for the random phases. They include one frame, the full
  // eight, a zero that must act as one and values above eight that must act
  // as eight. Reset happens only once, so every change here is a change of
  // count with frames still holding pages.
  logic [mlru_pkg::CFG_W-1:0] phase_frames [12] = '{
    4'd8, 4'd3, 4'd1, 4'd0, 4'd5, 4'd15, 4'd2, 4'd9, 4'd6, 4'd4, 4'd7, 4'd8
  };

  // Sender idle rates per phase: none, heavy, light.
  int idle_levels [3] = '{0, 46, 22};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  matrix_lru_page_replacement_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total)
  );

  mlru_replacement_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .hits_seen         (hits_seen),
    .evictions_seen    (evictions_seen)
  );

  // A hung core must not hang the run. The limit is many times the slowest
  // legal run: every reference evicting with eight frames plus the longest
  // sender gap.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[matrix_lru_page_replacement_core] ERROR");
      $finish;
    end
  end

  // Presents one reference beat and returns on the edge that takes it. The
  // caller is always at a rising edge here. busy only changes on rising edges,
  // so its value at the falling edge is what the next rising edge will see;
  // that keeps the handshake free of races with the core's own updates.
  task automatic send_ref(input logic [15:0] pg);
    logic was_busy;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_page_number <= pg;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    refs_sent++;
  endtask

  // Holds the sender off until every outstanding result beat has come back.
  // Each reference yields exactly one result, so an empty expectation queue
  // means the core is idle.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  // The frame count is only written while the core is idle.
  task automatic set_frames(input logic [mlru_pkg::CFG_W-1:0] count);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    settings_used++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [15:0] pg;
    logic [15:0] page_pool [$];
    int          pick;
    int          active;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_page_number = '0;
    idle_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_refs[k]) send_ref(opening_refs[k]);

    // A single frame: every miss evicts frame zero, repeats hit.
    set_frames(4'd1);
    send_ref(16'hAAAA);
    send_ref(16'hAAAA);
    send_ref(16'h0000);
    // Zero frames behave as one.
    set_frames(4'd0);
    send_ref(16'h0000);
    send_ref(16'hFFFF);
    // Counts above the frame limit behave as eight; the frames beyond the
    // first still hold their pages from the opening references.
    set_frames(4'd15);
    send_ref(16'h8000);
    send_ref(16'h0000);

    // Random phases. Most references come from a small pool of the active frame
    // count plus up to three pages, so hits, fills and evictions all occur
    // often. The rest are arbitrary pages or the field extremes.
    for (int ph = 0; ph < 12; ph++) begin
      set_frames(phase_frames[ph]);
      idle_pct = idle_levels[ph % 3];
      active = (phase_frames[ph] == 0) ? 1 :
               (phase_frames[ph] > 8) ? 8 : int'(phase_frames[ph]);
      page_pool.delete();
      repeat (active + $urandom_range(0, 3)) begin
        page_pool.insert(page_pool.size(), 16'($urandom));
      end
      repeat (54) begin
        pick = $urandom_range(99);
        // Now and then let the core run dry before the next beat.
        if (pick < 3) drain();
        if (pick < 12) pg = 16'($urandom);
        else if (pick < 15) pg = pick[0] ? 16'hFFFF : 16'h0000;
        else pg = page_pool[$urandom_range(page_pool.size() - 1)];
        send_ref(pg);
      end
    end

    // Wait out the last results, then a little longer than the slowest
    // eviction in case anything stray follows.
    drain();
    repeat (12) @(posedge clk);

    $display("Checked %0d page references across %0d frame count settings.",
             refs_sent, settings_used);
    $display("Results included %0d hits and %0d evictions.", hits_seen, evictions_seen);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[matrix_lru_page_replacement_core] OK");
    end else begin
      $display("[matrix_lru_page_replacement_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mlru_pkg.sv
hdl/mlru_ctrl.sv
hdl/mlru_datapath.sv
hdl/matrix_lru_page_replacement_core.sv
dv/mlru_replacement_checker.sv
dv/tb.sv
